// ===== rtl/bsl_pkg.sv =====
package bsl_pkg;

    // Bar count; BAR_W, SPAN_W, SPAN and HALF follow from it.
    localparam int NUM_BARS = 32;
    localparam int BAR_W    = $clog2(NUM_BARS);
    localparam int SPAN_W   = BAR_W + 8;
    localparam int SPAN     = NUM_BARS * 256;
    localparam int HALF     = NUM_BARS * 128;

    // Divider datapath widths.
    localparam int DIV_W = 25;
    localparam int CNT_W = 5;

    localparam logic [12:0] TEMPO_MIN  = 13'd960;
    localparam logic [8:0]  ENERGY_ONE = 9'd256;
    localparam logic [8:0]  THRESH_RST = 9'd204;

    // 60 s * 32 beats * 16 (Q9.4 tempo) in microseconds.
    localparam logic [34:0] CYCLE_NUM   = 35'd30720000000;
    // Strobe step = (elapsed * tempo * 16 + STROBE_BIAS) / STROBE_DIV, rounded half up.
    localparam logic [17:0] STROBE_DIV  = 18'd234375;
    localparam logic [32:0] STROBE_BIAS = 33'd117187;
    // floor(2^36 / STROBE_DIV); the estimate it gives is low by at most one.
    localparam logic [18:0] STROBE_RCP  = 19'd293203;

    localparam logic [16:0] GAUSS_TAB [0:32] = '{
        17'd65536, 17'd65026, 17'd63519, 17'd61086, 17'd57835, 17'd53908, 17'd49469,
        17'd44692, 17'd39749, 17'd34806, 17'd30005, 17'd25465, 17'd21276, 17'd17502,
        17'd14173, 17'd11300, 17'd8869, 17'd6854, 17'd5214, 17'd3905, 17'd2879,
        17'd2090, 17'd1494, 17'd1051, 17'd728, 17'd496, 17'd333, 17'd220, 17'd143,
        17'd92, 17'd58, 17'd36, 17'd22
    };

    localparam logic [16:0] SINE_TAB [0:16] = '{
        17'd0, 17'd6424, 17'd12785, 17'd19024, 17'd25080, 17'd30893, 17'd36410,
        17'd41576, 17'd46341, 17'd50660, 17'd54491, 17'd57798, 17'd60547, 17'd62714,
        17'd64277, 17'd65220, 17'd65536
    };

    typedef struct packed {
        logic [12:0] tempo_bpm;
        logic [8:0]  energy_level;
        logic [15:0] elapsed_us;
    } tick_t;

    typedef struct packed {
        logic [4:0] bar_index;
        logic [8:0] bar_level;
        logic [8:0] strobe_level;
        logic       last_bar;
    } bar_t;

    // One tick's worth of work for the bar generator.
    typedef struct packed {
        logic [SPAN_W-1:0] pos;
        logic [8:0]        energy;
        logic [8:0]        strobe;
    } job_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num_hi;
        logic [DIV_W-1:0] num_lo;
        logic [DIV_W-1:0] divisor;
        logic [CNT_W-1:0] count;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_CYCLE,
        FS_MOD,
        FS_POS,
        FS_STEP,
        FS_SINE,
        FS_STROBE,
        FS_PUSH
    } fstate_t;

endpackage

// ===== rtl/bsl_div.sv =====
module bsl_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  bsl_pkg::div_req_t req,
    output bsl_pkg::div_rsp_t rsp
);

    logic [bsl_pkg::DIV_W-1:0] rem_reg;
    logic [bsl_pkg::DIV_W-1:0] lo_reg;
    logic [bsl_pkg::DIV_W-1:0] quo_reg;
    logic [bsl_pkg::DIV_W-1:0] div_reg;
    logic [bsl_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [bsl_pkg::DIV_W:0]   trial;
    logic [bsl_pkg::DIV_W+1:0] diff;
    logic                      borrow;
    logic [bsl_pkg::DIV_W-1:0] rem_next;

    // The high part of the dividend is preloaded below the divisor, so only
    // the remaining low bits need a step each.
    always_comb
    begin
        trial    = {rem_reg, lo_reg[bsl_pkg::DIV_W-1]};
        diff     = {1'b0, trial} - {2'b00, div_reg};
        borrow   = diff[bsl_pkg::DIV_W+1];
        rem_next = borrow ? trial[bsl_pkg::DIV_W-1:0] : diff[bsl_pkg::DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.count;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == bsl_pkg::CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.num_hi;
            lo_reg  <= req.num_lo;
            div_reg <= req.divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            lo_reg  <= {lo_reg[bsl_pkg::DIV_W-2:0], 1'b0};
            quo_reg <= {quo_reg[bsl_pkg::DIV_W-2:0], ~borrow};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg && !done_reg)
        else $error("divider started while a division is still running");

endmodule

// ===== rtl/bsl_front.sv =====
module bsl_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick_valid,
    output logic                tick_ready,
    input  bsl_pkg::tick_t      tick,
    input  logic                thresh_we,
    input  logic [8:0]          thresh_data,
    output logic                job_valid,
    input  logic                job_ready,
    output bsl_pkg::job_t       job
);

    localparam int PW = bsl_pkg::DIV_W + bsl_pkg::SPAN_W;

    bsl_pkg::fstate_t  state_reg;
    bsl_pkg::fstate_t  state_next;
    bsl_pkg::div_req_t div_req;
    bsl_pkg::div_rsp_t div_rsp;

    logic                      issued_reg;
    logic [8:0]                thr_reg;
    logic [24:0]               sweep_reg;
    logic [15:0]               turns_reg;
    logic [12:0]               tempo_reg;
    logic [8:0]                energy_reg;
    logic [15:0]               elapsed_reg;
    logic [24:0]               cycle_reg;
    logic [bsl_pkg::SPAN_W-1:0] pos_reg;
    logic [16:0]               sine_reg;
    logic [8:0]                strobe_reg;
    logic [32:0]               step_num_reg;
    logic [15:0]               step_est_reg;
    logic [15:0]               step_reg;

    logic        accept;
    logic [12:0] tempo_c;
    logic [8:0]  energy_c;
    logic [25:0] sum_t;
    logic [PW-1:0] prod_pos;
    logic [28:0] prod_step;
    logic [32:0] num_step;
    logic [37:0] est_prod;
    logic [32:0] step_rem;
    logic        div_state;

    logic [14:0] q_ph;
    logic [4:0]  k_ph;
    logic [9:0]  f_ph;
    logic [16:0] s0;
    logic [16:0] s1;
    logic [26:0] sine_prod;
    logic [16:0] sine_val;
    logic [25:0] strobe_prod;

    bsl_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept   = tick_valid && tick_ready;
    assign tempo_c  = (tick.tempo_bpm < bsl_pkg::TEMPO_MIN) ? bsl_pkg::TEMPO_MIN
                                                            : tick.tempo_bpm;
    assign energy_c = (tick.energy_level > bsl_pkg::ENERGY_ONE) ? bsl_pkg::ENERGY_ONE
                                                                : tick.energy_level;

    // Dividend forms for the modulo and position divisions, and the strobe step numerator.
    assign sum_t     = 26'(sweep_reg) + 26'(elapsed_reg);
    assign prod_pos  = PW'(sweep_reg) * PW'(bsl_pkg::SPAN);
    assign prod_step = 29'(elapsed_reg) * 29'(tempo_reg);
    assign num_step  = {prod_step, 4'b0000} + bsl_pkg::STROBE_BIAS;

    // The strobe step divides by a constant: a reciprocal estimate, then one
    // correction from the remainder. These registers (step_num_reg, step_est_reg,
    // step_reg) settle in turn after the beat, long before FS_STEP reads the result.
    assign est_prod = 38'(step_num_reg[32:14]) * 38'(bsl_pkg::STROBE_RCP);
    assign step_rem = step_num_reg - 33'(step_est_reg) * 33'(bsl_pkg::STROBE_DIV);

    // Half-wave sine from the quarter-wave table.
    always_comb
    begin
        q_ph      = turns_reg[14] ? 15'(17'd32768 - 17'(turns_reg)) : turns_reg[14:0];
        k_ph      = q_ph[14:10];
        f_ph      = q_ph[9:0];
        s0        = bsl_pkg::SINE_TAB[{1'b0, k_ph[3:0]}];
        s1        = bsl_pkg::SINE_TAB[{1'b0, k_ph[3:0]} + 5'd1];
        sine_prod = 27'(s1 - s0) * 27'(f_ph);
        if (turns_reg[15])
            sine_val = '0;
        else if (k_ph[4])
            sine_val = bsl_pkg::SINE_TAB[16];
        else
            sine_val = s0 + 17'(sine_prod >> 10);
        strobe_prod = 26'(sine_reg) * 26'(energy_reg) + 26'd32768;
    end

    always_comb
    begin
        div_state = (state_reg == bsl_pkg::FS_CYCLE) || (state_reg == bsl_pkg::FS_MOD) ||
                    (state_reg == bsl_pkg::FS_POS);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsl_pkg::FS_IDLE:
            begin
                if (accept)
                    state_next = bsl_pkg::FS_CYCLE;
            end
            bsl_pkg::FS_CYCLE:
            begin
                if (div_rsp.done)
                    state_next = bsl_pkg::FS_MOD;
            end
            bsl_pkg::FS_MOD:
            begin
                if (div_rsp.done)
                    state_next = bsl_pkg::FS_POS;
            end
            bsl_pkg::FS_POS:
            begin
                if (div_rsp.done)
                    state_next = bsl_pkg::FS_STEP;
            end
            bsl_pkg::FS_STEP:
                state_next = bsl_pkg::FS_SINE;
            bsl_pkg::FS_SINE:
                state_next = bsl_pkg::FS_STROBE;
            bsl_pkg::FS_STROBE:
                state_next = bsl_pkg::FS_PUSH;
            bsl_pkg::FS_PUSH:
            begin
                if (job_ready)
                    state_next = bsl_pkg::FS_IDLE;
            end
            default:
                state_next = bsl_pkg::FS_IDLE;
        endcase
    end

    // Outputs and divider operands.
    always_comb
    begin
        tick_ready      = 1'b0;
        job_valid       = 1'b0;
        div_req.start   = div_state && !issued_reg;
        div_req.num_hi  = '0;
        div_req.num_lo  = '0;
        div_req.divisor = '0;
        div_req.count   = '0;
        case (state_reg)
            bsl_pkg::FS_IDLE:
                tick_ready = 1'b1;
            bsl_pkg::FS_CYCLE:
            begin
                div_req.num_hi  = {15'd0, bsl_pkg::CYCLE_NUM[34:25]};
                div_req.num_lo  = bsl_pkg::CYCLE_NUM[24:0];
                div_req.divisor = {12'd0, tempo_reg};
                div_req.count   = 5'd25;
            end
            bsl_pkg::FS_MOD:
            begin
                // The sum stays below sixteen sweep lengths, so four quotient bits cover it.
                div_req.num_hi  = {3'd0, sum_t[25:4]};
                div_req.num_lo  = {sum_t[3:0], 21'd0};
                div_req.divisor = cycle_reg;
                div_req.count   = 5'd4;
            end
            bsl_pkg::FS_POS:
            begin
                div_req.num_hi  = prod_pos[PW-1:bsl_pkg::SPAN_W];
                div_req.num_lo  = {prod_pos[bsl_pkg::SPAN_W-1:0],
                                   {(bsl_pkg::DIV_W-bsl_pkg::SPAN_W){1'b0}}};
                div_req.divisor = cycle_reg;
                div_req.count   = bsl_pkg::CNT_W'(bsl_pkg::SPAN_W);
            end
            bsl_pkg::FS_STEP:
                job_valid = 1'b0;
            bsl_pkg::FS_SINE:
                job_valid = 1'b0;
            bsl_pkg::FS_STROBE:
                job_valid = 1'b0;
            bsl_pkg::FS_PUSH:
                job_valid = 1'b1;
            default:
                job_valid = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bsl_pkg::FS_IDLE;
            issued_reg <= 1'b0;
            thr_reg    <= bsl_pkg::THRESH_RST;
            sweep_reg  <= '0;
            turns_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (thresh_we)
                thr_reg <= thresh_data;
            if (div_req.start)
                issued_reg <= 1'b1;
            else if (div_rsp.done)
                issued_reg <= 1'b0;
            if ((state_reg == bsl_pkg::FS_MOD) && div_rsp.done)
                sweep_reg <= div_rsp.rem;
            if (state_reg == bsl_pkg::FS_STEP)
                turns_reg <= turns_reg + step_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tempo_reg   <= tempo_c;
            energy_reg  <= energy_c;
            elapsed_reg <= tick.elapsed_us;
        end
        step_num_reg <= num_step;
        step_est_reg <= est_prod[37:22];
        step_reg     <= (step_rem >= 33'(bsl_pkg::STROBE_DIV)) ? step_est_reg + 16'd1
                                                               : step_est_reg;
        if ((state_reg == bsl_pkg::FS_CYCLE) && div_rsp.done)
            cycle_reg <= div_rsp.quo;
        if ((state_reg == bsl_pkg::FS_POS) && div_rsp.done)
            pos_reg <= div_rsp.quo[bsl_pkg::SPAN_W-1:0];
        if (state_reg == bsl_pkg::FS_SINE)
            sine_reg <= sine_val;
        if (state_reg == bsl_pkg::FS_STROBE)
            strobe_reg <= (energy_reg > thr_reg) ? strobe_prod[24:16] : 9'd0;
    end

    assign job.pos    = pos_reg;
    assign job.energy = energy_reg;
    assign job.strobe = strobe_reg;

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !tick_ready && !job_valid)
        else $error("front took a beat and did not start working on it");

endmodule

// ===== rtl/bsl_queue.sv =====
module bsl_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  bsl_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output bsl_pkg::job_t pop_data
);

    bsl_pkg::job_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push_ok;
    logic          pop_ok;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push_ok    = push_valid && push_ready;
    assign pop_ok     = pop_ready && pop_valid;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push_ok)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop_ok)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push_ok && !pop_ok)
                count_reg <= count_reg + 2'd1;
            else if (pop_ok && !push_ok)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != 2'd3) && ((count_reg == 2'd0) || (count_reg == 2'd2) ||
        (wr_ptr_reg != rd_ptr_reg)))
        else $error("queue fill count disagrees with its pointers");

endmodule

// ===== rtl/bsl_back.sv =====
module bsl_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  bsl_pkg::job_t job,
    output logic          bar_valid,
    input  logic          bar_ready,
    output bsl_pkg::bar_t bar
);

    localparam logic [bsl_pkg::BAR_W-1:0] LAST_IDX = bsl_pkg::BAR_W'(bsl_pkg::NUM_BARS - 1);

    bsl_pkg::job_t job_reg;
    logic          busy_reg;
    logic [bsl_pkg::BAR_W-1:0] idx_reg;

    logic                      s1_valid_reg;
    logic [16:0]               s1_gauss_reg;
    logic [bsl_pkg::BAR_W-1:0] s1_idx_reg;
    logic [8:0]                s1_energy_reg;
    logic [8:0]                s1_strobe_reg;
    logic                      s1_last_reg;

    logic          out_valid_reg;
    bsl_pkg::bar_t bar_reg;

    logic                        advance;
    logic                        issue;
    logic [bsl_pkg::SPAN_W-1:0]  at;
    logic [bsl_pkg::SPAN_W-1:0]  d_raw;
    logic [bsl_pkg::SPAN_W:0]    d_wrap;
    logic [bsl_pkg::SPAN_W-1:0]  d;
    logic [15:0]                 dz;
    logic                        far;
    logic [4:0]                  j;
    logic [5:0]                  f;
    logic [16:0]                 g0;
    logic [16:0]                 g1;
    logic [22:0]                 g_prod;
    logic [16:0]                 gauss;
    logic [25:0]                 lvl_prod;

    // The whole pipe moves whenever the output register is free or being taken.
    assign advance   = !out_valid_reg || bar_ready;
    assign issue     = busy_reg && advance;
    assign job_ready = !busy_reg;

    always_comb
    begin
        at     = {idx_reg, 8'h00};
        d_raw  = (at > job_reg.pos) ? at - job_reg.pos : job_reg.pos - at;
        d_wrap = (bsl_pkg::SPAN_W + 1)'(bsl_pkg::SPAN) - {1'b0, d_raw};
        d      = (d_raw > bsl_pkg::SPAN_W'(bsl_pkg::HALF)) ? d_wrap[bsl_pkg::SPAN_W-1:0]
                                                           : d_raw;
        dz     = 16'(d);
        // From eight bars on, the Gaussian is taken as zero.
        far    = (dz >= 16'd2048);
        j      = dz[10:6];
        f      = dz[5:0];
        g0     = bsl_pkg::GAUSS_TAB[{1'b0, j}];
        g1     = bsl_pkg::GAUSS_TAB[{1'b0, j} + 6'd1];
        g_prod = 23'(g0 - g1) * 23'(f);
        gauss  = far ? 17'd0 : g0 - 17'(g_prod >> 6);
        lvl_prod = 26'(s1_gauss_reg) * 26'(s1_energy_reg) + 26'd32768;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!busy_reg && job_valid)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (issue)
            begin
                if (idx_reg == LAST_IDX)
                    busy_reg <= 1'b0;
                idx_reg <= idx_reg + 1'b1;
            end
            if (advance)
            begin
                s1_valid_reg  <= issue;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && job_valid)
            job_reg <= job;
        if (advance)
        begin
            s1_gauss_reg      <= gauss;
            s1_idx_reg        <= idx_reg;
            s1_energy_reg     <= job_reg.energy;
            s1_strobe_reg     <= job_reg.strobe;
            s1_last_reg       <= (idx_reg == LAST_IDX);
            bar_reg.bar_index    <= 5'(s1_idx_reg);
            bar_reg.bar_level    <= lvl_prod[24:16];
            bar_reg.strobe_level <= s1_strobe_reg;
            bar_reg.last_bar     <= s1_last_reg;
        end
    end

    assign bar_valid = out_valid_reg;
    assign bar       = bar_reg;

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bar_reg.last_bar) |->
        (bar_reg.bar_index == 5'(bsl_pkg::NUM_BARS - 1)))
        else $error("last bar flag on a bar other than the final one");

    a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !$past(busy_reg) && $past(advance)) |-> 1'b0)
        else $error("bar issued without a tick in progress");

endmodule

// ===== rtl/beat_synced_led_bar_sweep.sv =====
// Channel   Direction  Handshake                 Payload
// tick      in         tick_valid / tick_ready   bsl_pkg::tick_t (tempo, energy, elapsed)
// bar       out        bar_valid / bar_ready     bsl_pkg::bar_t (index, level, strobe, last)
// thresh    in         thresh_we                 thresh_data, 9-bit strobe threshold
//
// The front takes one tick beat and works it through a shared radix-2 divider
// (cycle length, sweep modulo, sweep position: 42 steps in all, with a handoff
// after each division), a reciprocal multiply for the strobe step and the sine table,
// and takes no new tick until the job for the current one has been pushed.
// The back emits NUM_BARS bar beats per tick, one per cycle while the output is not stalled,
// then picks up the next job once idle; a two-entry queue lets the front run ahead.
// Reset sets the threshold to 204 and both phases to zero; no clearing pass.
// A stalled bar output holds the back while the front keeps working until the queue fills.
module beat_synced_led_bar_sweep
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tick_valid,
    output logic           tick_ready,
    input  bsl_pkg::tick_t tick,
    output logic           bar_valid,
    input  logic           bar_ready,
    output bsl_pkg::bar_t  bar,
    input  logic           thresh_we,
    input  logic [8:0]     thresh_data
);

    logic          f_valid;
    logic          f_ready;
    bsl_pkg::job_t f_job;
    logic          b_valid;
    logic          b_ready;
    bsl_pkg::job_t b_job;

    bsl_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_valid  (tick_valid),
        .tick_ready  (tick_ready),
        .tick        (tick),
        .thresh_we   (thresh_we),
        .thresh_data (thresh_data),
        .job_valid   (f_valid),
        .job_ready   (f_ready),
        .job         (f_job)
    );

    bsl_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_job),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_job)
    );

    bsl_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job       (b_job),
        .bar_valid (bar_valid),
        .bar_ready (bar_ready),
        .bar       (bar)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int BARS      = bsl_pkg::NUM_BARS;
    localparam int CYC_LIMIT = 600000;
    localparam int HOLD_LEN  = 600;
    localparam int SETTLE    = 100;
    localparam int MAX_SHOWN = 40;

    // exp(-d*d/8) in Q1.16 at quarter-bar steps, and a quarter sine wave in Q1.16.
    localparam int unsigned GAUSS_Q16 [0:32] = '{
        65536, 65026, 63519, 61086, 57835, 53908, 49469, 44692,
        39749, 34806, 30005, 25465, 21276, 17502, 14173, 11300,
        8869, 6854, 5214, 3905, 2879, 2090, 1494, 1051,
        728, 496, 333, 220, 143, 92, 58, 36,
        22
    };
    localparam int unsigned SINE_Q16 [0:16] = '{
        0, 6424, 12785, 19024, 25080, 30893, 36410, 41576,
        46341, 50660, 54491, 57798, 60547, 62714, 64277, 65220,
        65536
    };

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            tick_valid = 1'b0;
    logic            tick_ready;
    bsl_pkg::tick_t  tick = '0;
    logic            bar_valid;
    logic            bar_ready = 1'b0;
    bsl_pkg::bar_t   bar;
    logic            thresh_we = 1'b0;
    logic [8:0]      thresh_data = 9'd0;

    bsl_pkg::tick_t  ticks_pending [$];
    bsl_pkg::bar_t   bars_due [$];

    // Shadow copy of the block's state and threshold.
    longint unsigned sweep_us;
    int unsigned     strobe_phase;
    int unsigned     strobe_thresh;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int ticks_taken = 0;
    int bars_checked = 0;
    int strobe_ticks = 0;
    int cycle_count = 0;
    int hold_left = 0;
    logic hold_arm = 1'b0;
    logic hold_done = 1'b0;

    beat_synced_led_bar_sweep dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_valid  (tick_valid),
        .tick_ready  (tick_ready),
        .tick        (tick),
        .bar_valid   (bar_valid),
        .bar_ready   (bar_ready),
        .bar         (bar),
        .thresh_we   (thresh_we),
        .thresh_data (thresh_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int unsigned gauss_at(int unsigned d);
        int unsigned j;
        int unsigned f;
        j = d >> 6;
        f = d & 63;
        if (j >= 32)
            return 0;
        return GAUSS_Q16[j] - (((GAUSS_Q16[j] - GAUSS_Q16[j + 1]) * f) >> 6);
    endfunction

    function automatic int unsigned positive_sine(int unsigned phase);
        int unsigned q;
        int unsigned k;
        int unsigned f;
        phase = phase & 16'hFFFF;
        if (phase >= 32768)
            return 0;
        q = (phase >= 16384) ? 32768 - phase : phase;
        k = q >> 10;
        f = q & 1023;
        if (k >= 16)
            return SINE_Q16[16];
        return SINE_Q16[k] + (((SINE_Q16[k + 1] - SINE_Q16[k]) * f) >> 10);
    endfunction

    // Advances the shadow state by one tick and queues the bar beats it produces.
    task automatic sweep_tick(input bsl_pkg::tick_t t);
        longint unsigned tempo;
        longint unsigned energy;
        longint unsigned cyc;
        longint unsigned pos;
        longint unsigned step;
        int unsigned     strobe;
        int unsigned     d;
        int unsigned     at;
        bsl_pkg::bar_t   b;
        tempo  = (t.tempo_bpm < 13'd960) ? 960 : t.tempo_bpm;
        energy = (t.energy_level > 9'd256) ? 256 : t.energy_level;
        cyc    = 64'd30720000000 / tempo;
        sweep_us = (sweep_us + t.elapsed_us) % cyc;
        pos    = (sweep_us * BARS * 256) / cyc;
        step   = (64'(t.elapsed_us) * tempo * 65536 + 64'd480000000) / 64'd960000000;
        strobe_phase = (strobe_phase + int'(step)) & 16'hFFFF;
        strobe = 0;
        if (energy > strobe_thresh)
            strobe = (positive_sine(strobe_phase) * int'(energy) + 32768) >> 16;
        if (strobe != 0)
            strobe_ticks++;
        for (int i = 0; i < BARS; i++)
        begin
            at = i * 256;
            d = (at > pos) ? at - int'(pos) : int'(pos) - at;
            if (d > BARS * 128)
                d = BARS * 256 - d;
            b.bar_index    = 5'(i);
            b.bar_level    = 9'((gauss_at(d) * int'(energy) + 32768) >> 16);
            b.strobe_level = 9'(strobe);
            b.last_bar     = (i == BARS - 1);
            bars_due.insert(bars_due.size(), b);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < MAX_SHOWN)
            $display("mismatch at beat %0d: %s got %0d, expected %0d",
                     bars_checked, what, got, want);
        errors++;
    endtask

    function automatic bsl_pkg::tick_t pack_tick(int tempo, int energy, int elapsed);
        bsl_pkg::tick_t t;
        t.tempo_bpm    = 13'(tempo);
        t.energy_level = 9'(energy);
        t.elapsed_us   = 16'(elapsed);
        return t;
    endfunction

    task automatic add_tick(input bsl_pkg::tick_t t);
        ticks_pending.insert(ticks_pending.size(), t);
    endtask

    function automatic bsl_pkg::tick_t random_tick();
        int tempo;
        int energy;
        int elapsed;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            tempo = $urandom_range(960, 2880);
        else if (pick < 75)
            tempo = $urandom_range(0, 8191);
        else if (pick < 85)
            tempo = $urandom_range(0, 959);
        else
            tempo = $urandom_range(2881, 8191);
        pick = $urandom_range(0, 99);
        energy = (pick < 30) ? $urandom_range(180, 256) : $urandom_range(0, 511);
        pick = $urandom_range(0, 99);
        if (pick < 40)
            elapsed = $urandom_range(15000, 17500);
        else if (pick < 60)
            elapsed = $urandom_range(0, 65535);
        else if (pick < 70)
            elapsed = 0;
        else
            elapsed = $urandom_range(0, 33000);
        return pack_tick(tempo, energy, elapsed);
    endfunction

    // Sender: a tick beat stays on the port until it is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tick_valid && tick_ready)
            begin
                sweep_tick(tick);
                ticks_taken++;
            end
            if (!tick_valid || tick_ready)
            begin
                if (ticks_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    tick_valid <= 1'b1;
                    tick       <= ticks_pending.pop_front();
                end
                else
                begin
                    tick_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when armed.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                bar_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (hold_arm && !hold_done)
            begin
                bar_ready <= 1'b0;
                hold_left <= HOLD_LEN;
                hold_done <= 1'b1;
            end
            else
            begin
                bar_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        bsl_pkg::bar_t want;
        if (rst_n && bar_valid && bar_ready)
        begin
            if (bars_due.size() == 0)
            begin
                report_mismatch("unexpected bar beat, index", bar.bar_index, -1);
            end
            else
            begin
                want = bars_due.pop_front();
                if (bar.bar_index != want.bar_index)
                    report_mismatch("bar_index", bar.bar_index, want.bar_index);
                if (bar.bar_level != want.bar_level)
                    report_mismatch("bar_level", bar.bar_level, want.bar_level);
                if (bar.strobe_level != want.strobe_level)
                    report_mismatch("strobe_level", bar.strobe_level, want.strobe_level);
                if (bar.last_bar != want.last_bar)
                    report_mismatch("last_bar", bar.last_bar, want.last_bar);
            end
            bars_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYC_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bar beats outstanding",
                     cycle_count, bars_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Checked on the falling edge, once the rising-edge updates have all landed.
    task automatic drain();
        while (ticks_pending.size() != 0 || tick_valid || bars_due.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_threshold(input int unsigned value);
        @(posedge clk);
        thresh_we     <= 1'b1;
        thresh_data   <= 9'(value);
        strobe_thresh = value;
        @(posedge clk);
        thresh_we <= 1'b0;
    endtask

    initial
    begin
        sweep_us      = 0;
        strobe_phase  = 0;
        strobe_thresh = 204;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 32;
        recv_idle_pct = 76;
        // Directed ticks at the reset threshold: clamps, zero elapsed time,
        // a long run at the slowest tempo followed by a jump to the fastest.
        add_tick(pack_tick(0, 0, 0));
        add_tick(pack_tick(960, 256, 16666));
        add_tick(pack_tick(8191, 511, 65535));
        add_tick(pack_tick(959, 257, 65535));
        add_tick(pack_tick(8191, 256, 0));
        for (int i = 0; i < 8; i++)
            add_tick(pack_tick(960, 255, 65535));
        add_tick(pack_tick(8191, 256, 1));
        add_tick(pack_tick(1920, 205, 10000));
        add_tick(pack_tick(1920, 204, 10000));
        add_tick(pack_tick(2000, 511, 1));
        add_tick(pack_tick(4000, 300, 12345));
        add_tick(pack_tick(1920, 256, 0));
        add_tick(pack_tick(2304, 170, 43690));
        add_tick(pack_tick(4096, 85, 21845));
        drain();

        write_threshold(0);
        for (int i = 0; i < 110; i++)
            add_tick(random_tick());
        drain();

        send_idle_pct = 76;
        recv_idle_pct = 32;
        // With the threshold at full scale the strobe stays dark.
        write_threshold(256);
        for (int i = 0; i < 110; i++)
            add_tick(random_tick());
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold($urandom_range(120, 250));
        for (int i = 0; i < 100; i++)
            add_tick(random_tick());
        repeat (200) @(posedge clk);
        hold_arm = 1'b1;
        while (ticks_pending.size() != 0 || tick_valid || bars_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d ticks and %0d bar beats over four threshold settings",
                 ticks_taken, bars_checked);
        $display("%0d ticks lit the strobe, %0d mismatches", strobe_ticks, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bsl_pkg.sv
rtl/bsl_div.sv
rtl/bsl_front.sv
rtl/bsl_queue.sv
rtl/bsl_back.sv
rtl/beat_synced_led_bar_sweep.sv
tb/testbench.sv
